@@ hdl/rmsr_pkg.sv @@
package rmsr_pkg;

  localparam logic [14:0] Mult     = 15'd16807;
  localparam logic [32:0] Mask31   = 33'h0_7FFF_FFFF;
  localparam int unsigned DivSteps = 31;
  localparam int unsigned DivCntW  = 5;
  localparam int unsigned DrawW    = 5;

  typedef struct packed {
    logic signed [31:0] low_bound;
    logic signed [31:0] high_bound;
    logic               use_exclusion;
    logic signed [31:0] excluded_value;
  } rmsr_in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic        [30:0] generator_value;
    logic        [4:0]  draws_used;
    logic               exclusion_failed;
  } rmsr_out_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_FOLD  = 6'b000100,
    S_DIV   = 6'b001000,
    S_CHECK = 6'b010000,
    S_DONE  = 6'b100000
  } rmsr_state_e;

  typedef struct packed {
    logic accept;
    logic mul;
    logic fold;
    logic div_step;
    logic check;
    logic out_load;
  } rmsr_cmd_t;

  typedef struct packed {
    logic bounds_equal;
    logic hit_excluded;
  } rmsr_status_t;

endpackage

@@ hdl/rmsr_dp.sv @@
module rmsr_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rmsr_pkg::rmsr_in_t     in_word_i,
  input  logic                   cfg_we_i,
  input  logic [30:0]            cfg_data_i,
  input  rmsr_pkg::rmsr_cmd_t    cmd_i,
  output rmsr_pkg::rmsr_status_t status_o,
  output rmsr_pkg::rmsr_out_t    out_word_o
);

  logic [30:0] gen_q, gen_d;
  logic [30:0] prod_lo_q;
  logic [29:0] prod_hi_q;
  logic [31:0] low_q, avoid_q, mag_q, result_q;
  logic        excl_q;
  logic [31:0] rem_q;
  logic [30:0] dvd_q;
  logic [rmsr_pkg::DrawW-1:0] draws_q;
  rmsr_pkg::rmsr_out_t out_q;

  logic [31:0] in_diff, in_mag, sum;
  logic [32:0] fold_sum, fold_red, trial, trial_sub;

  assign in_diff = 32'(in_word_i.high_bound) - 32'(in_word_i.low_bound);
  assign in_mag  = in_diff[31] ? (32'd0 - in_diff) : in_diff;

  assign fold_sum = 33'(prod_lo_q) + {2'b00, prod_hi_q[14:0], 16'h0000}
                  + 33'(prod_hi_q[29:15]);
  assign fold_red = (fold_sum > rmsr_pkg::Mask31) ? (fold_sum - rmsr_pkg::Mask31)
                                                  : fold_sum;
  assign gen_d    = fold_red[30:0];

  assign trial     = {rem_q, dvd_q[30]};
  assign trial_sub = trial - {1'b0, mag_q};
  assign sum       = rem_q + low_q;

  assign status_o.bounds_equal = (in_word_i.low_bound == in_word_i.high_bound);
  assign status_o.hit_excluded = excl_q && (sum == avoid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= 31'd1;
    end else if (cfg_we_i) begin
      gen_q <= cfg_data_i;
    end else if (cmd_i.fold) begin
      gen_q <= gen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      low_q    <= 32'(in_word_i.low_bound);
      avoid_q  <= 32'(in_word_i.excluded_value);
      excl_q   <= in_word_i.use_exclusion;
      mag_q    <= in_mag;
      result_q <= 32'(in_word_i.low_bound);
      draws_q  <= '0;
    end
    if (cmd_i.mul) begin
      prod_lo_q <= 31'(rmsr_pkg::Mult) * 31'(gen_q[15:0]);
      prod_hi_q <= 30'(rmsr_pkg::Mult) * 30'(gen_q[30:16]);
    end
    if (cmd_i.fold) begin
      rem_q <= '0;
      dvd_q <= gen_d;
      if (draws_q != '1) begin
        draws_q <= draws_q + 1'b1;
      end
    end
    if (cmd_i.div_step) begin
      rem_q <= trial_sub[32] ? trial[31:0] : trial_sub[31:0];
      dvd_q <= {dvd_q[29:0], 1'b0};
    end
    if (cmd_i.check) begin
      result_q <= sum;
    end
    if (cmd_i.out_load) begin
      out_q.value            <= result_q;
      out_q.generator_value  <= gen_q;
      out_q.draws_used       <= draws_q;
      out_q.exclusion_failed <= excl_q && (result_q == avoid_q);
    end
  end

  assign out_word_o = out_q;

endmodule

@@ hdl/rmsr_ctrl.sv @@
module rmsr_ctrl #(
  parameter int unsigned MAX_RETRIES = 20
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  rmsr_pkg::rmsr_status_t status_i,
  output rmsr_pkg::rmsr_cmd_t    cmd_o
);

  localparam int unsigned TryW = $clog2(MAX_RETRIES + 2);
  localparam logic [TryW-1:0] TryMax = TryW'(MAX_RETRIES);
  localparam logic [rmsr_pkg::DivCntW-1:0] DivLast =
    rmsr_pkg::DivCntW'(rmsr_pkg::DivSteps - 1);

  rmsr_pkg::rmsr_state_e state_q, state_d;
  logic [rmsr_pkg::DivCntW-1:0] div_cnt_q, div_cnt_d;
  logic [TryW-1:0] tries_q, tries_d;
  logic out_valid_q, out_valid_d;
  logic accept, out_free;

  assign in_ready_o = (state_q == rmsr_pkg::S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    div_cnt_d = div_cnt_q;
    tries_d   = tries_q;
    cmd_o     = '0;
    case (state_q)
      rmsr_pkg::S_IDLE: begin
        if (accept) begin
          cmd_o.accept = 1'b1;
          tries_d      = '0;
          state_d      = status_i.bounds_equal ? rmsr_pkg::S_DONE : rmsr_pkg::S_MUL;
        end
      end
      rmsr_pkg::S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = rmsr_pkg::S_FOLD;
      end
      rmsr_pkg::S_FOLD: begin
        cmd_o.fold = 1'b1;
        div_cnt_d  = '0;
        state_d    = rmsr_pkg::S_DIV;
      end
      rmsr_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (div_cnt_q == DivLast) begin
          div_cnt_d = '0;
          state_d   = rmsr_pkg::S_CHECK;
        end else begin
          div_cnt_d = div_cnt_q + 1'b1;
        end
      end
      rmsr_pkg::S_CHECK: begin
        cmd_o.check = 1'b1;
        if (status_i.hit_excluded && (tries_q < TryMax)) begin
          tries_d = tries_q + 1'b1;
          state_d = rmsr_pkg::S_MUL;
        end else begin
          state_d = rmsr_pkg::S_DONE;
        end
      end
      rmsr_pkg::S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = rmsr_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = rmsr_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rmsr_pkg::S_IDLE;
      div_cnt_q   <= '0;
      tries_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_cnt_q   <= div_cnt_d;
      tries_q     <= tries_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_tries_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tries_q <= TryMax)
    else $error("retry count past limit");

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_cnt_q <= DivLast)
    else $error("divider step count past last step");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output word overwritten before taken");

  a_draw_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !status_i.bounds_equal) |=> state_q == rmsr_pkg::S_MUL)
    else $error("draw not started after accept");

endmodule

@@ hdl/ranged_minimal_standard_rng.sv @@
// with equal bounds no draw is made and the low bound is returned
// each draw: a multiply step, a fold step, a bit-serial remainder, then a check
// a new word is accepted only once the previous result has been moved to the output register
// the next word is accepted while a finished result waits in the output register
// reset: generator state 1, no word in flight, output empty

module ranged_minimal_standard_rng #(
  parameter int unsigned MAX_RETRIES = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rmsr_pkg::rmsr_in_t   in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rmsr_pkg::rmsr_out_t  out_word_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [30:0]          cfg_data_i
);

  rmsr_pkg::rmsr_cmd_t    cmd;
  rmsr_pkg::rmsr_status_t status;

  assign cfg_ready_o = 1'b1;

  rmsr_ctrl #(
    .MAX_RETRIES (MAX_RETRIES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rmsr_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_word_o (out_word_o)
  );

endmodule

@@ tb/ranged_minimal_standard_rng_tb.sv @@
module ranged_minimal_standard_rng_tb;

  localparam int unsigned MAX_RETRIES    = 20;
  localparam int unsigned LATENCY_CYCLES = 34 * (MAX_RETRIES + 1) + 2;
  localparam int unsigned HOLD_OFF_CYCLES = 3000;
  localparam int unsigned CYCLE_LIMIT    = 2_000_000;
  localparam int unsigned RANDOM_WORDS   = 220;
  localparam logic [63:0] MULTIPLIER     = 64'd16807;
  localparam logic [63:0] MODULUS        = 64'h7FFF_FFFF;
  localparam logic [31:0] MOST_NEGATIVE  = 32'h8000_0000;
  localparam logic [31:0] MOST_POSITIVE  = 32'h7FFF_FFFF;

  class rng_scoreboard;
    logic [30:0]          gen_state;
    rmsr_pkg::rmsr_out_t  awaited_words[$];
    int                   fail_count;

    function new();
      gen_state = 31'd1;
      fail_count = 0;
    endfunction

    function void load_seed(logic [30:0] seed);
      gen_state = seed;
    endfunction

    // one minimal standard step, split into 16-bit and 15-bit halves
    function logic [30:0] advance_generator();
      logic [63:0] lo;
      logic [63:0] hi;
      lo = MULTIPLIER * ({33'd0, gen_state} & 64'hFFFF);
      hi = MULTIPLIER * ({33'd0, gen_state} >> 16);
      lo = lo + ((hi & 64'h7FFF) << 16);
      lo = lo + (hi >> 15);
      if (lo > MODULUS) lo = lo - MODULUS;
      gen_state = lo[30:0];
      return gen_state;
    endfunction

    function logic [31:0] draw_in_span(logic [31:0] base, logic [31:0] span);
      logic [31:0] r;
      r = {1'b0, advance_generator()};
      return (r % span) + base;
    endfunction

    function void note_request(rmsr_pkg::rmsr_in_t w);
      rmsr_pkg::rmsr_out_t e;
      logic [31:0] diff;
      logic [31:0] span;
      logic [31:0] result;
      int unsigned draws;
      draws = 0;
      if (w.low_bound == w.high_bound) begin
        result = w.low_bound;
      end else begin
        diff = w.high_bound - w.low_bound;
        span = diff[31] ? -diff : diff;
        if (span == 0) span = MOST_NEGATIVE;
        result = draw_in_span(w.low_bound, span);
        draws = 1;
        if (w.use_exclusion) begin
          while (result == w.excluded_value && draws <= MAX_RETRIES) begin
            result = draw_in_span(w.low_bound, span);
            draws++;
          end
        end
      end
      e.value = result;
      e.generator_value = gen_state;
      e.draws_used = (draws > 31) ? 5'd31 : draws[4:0];
      e.exclusion_failed = w.use_exclusion && (result == w.excluded_value);
      awaited_words.push_back(e);
    endfunction

    function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (act_val !== exp_val) begin
        $error("%s: expected %0h, got %0h", name, exp_val, act_val);
        fail_count++;
      end
    endfunction

    function void check_result(rmsr_pkg::rmsr_out_t got);
      rmsr_pkg::rmsr_out_t e;
      if (awaited_words.size() == 0) begin
        $error("unexpected word: value %0h", got.value);
        fail_count++;
        return;
      end
      e = awaited_words.pop_front();
      compare_field("value", e.value, got.value);
      compare_field("generator_value", e.generator_value, got.generator_value);
      compare_field("draws_used", e.draws_used, got.draws_used);
      compare_field("exclusion_failed", e.exclusion_failed, got.exclusion_failed);
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  rmsr_pkg::rmsr_in_t  in_word = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  rmsr_pkg::rmsr_out_t out_word;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [30:0]         cfg_data = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_off_requests = 0;
  int unsigned hold_off_served = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;

  rng_scoreboard sb = new();

  ranged_minimal_standard_rng #(
    .MAX_RETRIES(MAX_RETRIES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) sb.load_seed(cfg_data);
      if (in_valid && in_ready) sb.note_request(in_word);
      if (out_valid && out_ready) sb.check_result(out_word);
    end
  end

  // receiver, with a single long hold-off in the first random phase
  always @(posedge clk_i) begin
    if (hold_left == 0 && hold_off_served != hold_off_requests) begin
      hold_off_served = hold_off_requests;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic rmsr_pkg::rmsr_in_t request_word(logic [31:0] lo, logic [31:0] hi,
                                                      logic excl, logic [31:0] avoid);
    rmsr_pkg::rmsr_in_t w;
    w.low_bound = lo;
    w.high_bound = hi;
    w.use_exclusion = excl;
    w.excluded_value = avoid;
    return w;
  endfunction

  // narrow spans in 45 of 100 picks, equal bounds in 10, so that exclusion retries happen often
  function automatic rmsr_pkg::rmsr_in_t random_request();
    rmsr_pkg::rmsr_in_t w;
    int unsigned        pick;
    int unsigned        span;
    pick = $urandom_range(99);
    w = request_word($urandom, $urandom, 1'($urandom_range(1)), $urandom);
    if (pick < 10) begin
      w.high_bound = w.low_bound;
      if ($urandom_range(1)) w.excluded_value = w.low_bound;
    end else if (pick < 55) begin
      span = $urandom_range(16, 1);
      w.high_bound = $urandom_range(1) ? w.low_bound + span : w.low_bound - span;
      if ($urandom_range(3) != 0) w.excluded_value = w.low_bound + $urandom_range(span - 1, 0);
    end
    return w;
  endfunction

  task automatic send_request(input rmsr_pkg::rmsr_in_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic write_seed(input logic [30:0] seed);
    cfg_valid <= 1'b1;
    cfg_data <= seed;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.awaited_words.size() != 0) @(posedge clk_i);
    repeat (LATENCY_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    logic [30:0] phase_seed[4];
    int unsigned idle_pct[4];
    int unsigned stall_pct[4];
    phase_seed = '{31'h7FFF_FFFE, 31'h7FFF_FFFF, 31'($urandom_range(2147483646, 1)), 31'd1};
    idle_pct = '{0, 87, 0, 31};
    stall_pct = '{0, 0, 87, 31};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words under the reset seed
    send_request(request_word(32'd0, 32'd0, 1'b0, 32'd0));
    send_request(request_word(32'd5, 32'd5, 1'b1, 32'd5));
    send_request(request_word(MOST_POSITIVE, MOST_POSITIVE, 1'b1, MOST_POSITIVE));
    send_request(request_word(MOST_NEGATIVE, MOST_NEGATIVE, 1'b0, MOST_NEGATIVE));
    send_request(request_word(MOST_NEGATIVE, MOST_POSITIVE, 1'b0, 32'd0));
    send_request(request_word(MOST_POSITIVE, MOST_NEGATIVE, 1'b0, 32'd0));
    send_request(request_word(32'd0, MOST_NEGATIVE, 1'b0, 32'd0));
    send_request(request_word(MOST_NEGATIVE, 32'd0, 1'b1, 32'd1));
    send_request(request_word(32'd10, 32'd0, 1'b0, 32'd0));
    send_request(request_word(-32'sd100, 32'sd100, 1'b0, 32'd0));
    send_request(request_word(32'd0, MOST_POSITIVE, 1'b1, 32'd12345));
    send_request(request_word(32'd7, 32'd8, 1'b1, 32'd7));
    send_request(request_word(32'd7, 32'd8, 1'b1, 32'd8));
    send_request(request_word(32'd0, 32'd2, 1'b1, 32'd0));
    send_request(request_word(32'd0, 32'd2, 1'b1, 32'd1));
    send_request(request_word(32'hFFFF_FFFF, 32'd1, 1'b1, 32'hFFFF_FFFF));
    send_request(request_word(MOST_POSITIVE, MOST_POSITIVE - 3, 1'b0, 32'd0));
    send_request(request_word(32'h7FFF_FFF0, 32'h8000_0010, 1'b1, 32'h8000_0000));
    send_request(request_word(-32'sd5, -32'sd4, 1'b0, 32'd0));
    send_request(request_word($urandom, $urandom, 1'b1, $urandom));
    drain();

    // a zero seed never leaves zero
    write_seed(31'd0);
    send_request(request_word(32'd0, 32'd10, 1'b0, 32'd0));
    send_request(request_word(32'd3, 32'd4, 1'b1, 32'd3));
    send_request(request_word(32'd3, 32'd100, 1'b1, 32'd3));
    repeat (15) send_request(random_request());
    drain();

    for (int p = 0; p < 4; p++) begin
      write_seed(phase_seed[p]);
      send_idle_pct = idle_pct[p];
      recv_stall_pct = stall_pct[p];
      if (p == 0) hold_off_requests++;
      repeat (RANDOM_WORDS) send_request(random_request());
      drain();
    end

    if (sb.fail_count == 0 && sb.awaited_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/rmsr_pkg.sv
hdl/rmsr_dp.sv
hdl/rmsr_ctrl.sv
hdl/ranged_minimal_standard_rng.sv
tb/ranged_minimal_standard_rng_tb.sv
